// ----- hdl/lale_pkg.sv -----
// Package for the LMS adaptive line enhancer.
// Sizes, number formats, register indexes and reset values. No dependencies.
`default_nettype none

package lale_pkg;

  localparam int MAX_TAPS    = 32;
  localparam int MAX_DELAY   = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int WEIGHT_BITS = 32;
  localparam int MU_BITS     = 16;
  localparam int PRED_SHIFT  = 28;
  localparam int UPD_SHIFT   = 2 * SAMPLE_BITS - 15;

  localparam int TAP_IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_CW = $clog2(MAX_TAPS + 1);
  localparam int DLY_IW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DLY_CW = $clog2(MAX_DELAY + 1);

  // Multiplier operand A carries a weight, mu or mu*error; it is sized for the wider of a weight and mu*error.
  localparam int OPA_BITS  = (SAMPLE_BITS + MU_BITS > WEIGHT_BITS) ?
                             SAMPLE_BITS + MU_BITS : WEIGHT_BITS;
  localparam int PROD_BITS = OPA_BITS + SAMPLE_BITS;
  localparam int ACC_BITS  = PROD_BITS + TAP_CW;

  localparam int TAPCFG_BITS   = 6;
  localparam int DLYCFG_BITS   = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRED_DELAY = 2'd2;

  localparam logic [TAPCFG_BITS-1:0] TAP_COUNT_RST  = 6'd32;
  localparam logic [MU_BITS-1:0]     STEP_SIZE_RST  = 16'd66;
  localparam logic [DLYCFG_BITS-1:0] PRED_DELAY_RST = 5'd5;

endpackage

`default_nettype wire

// ----- hdl/lale_in_if.sv -----
// Sample input channel: valid/ready plus one sample and the last-sample flag.
// Depends on lale_pkg.
`default_nettype none

interface lale_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lale_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                   last_sample;

  modport source (output valid, output sample_in, output last_sample, input ready);
  modport sink   (input valid, input sample_in, input last_sample, output ready);
endinterface

`default_nettype wire

// ----- hdl/lale_out_if.sv -----
// Result channel: valid/ready plus prediction and prediction error.
// Depends on lale_pkg.
`default_nettype none

interface lale_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lale_pkg::SAMPLE_BITS-1:0] prediction;
  logic signed [lale_pkg::SAMPLE_BITS-1:0] pred_error;

  modport source (output valid, output prediction, output pred_error, input ready);
  modport sink   (input valid, input prediction, input pred_error, output ready);
endinterface

`default_nettype wire

// ----- hdl/lale_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on lale_pkg.
`default_nettype none

interface lale_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lale_pkg::CFG_IDX_BITS-1:0]  index;
  logic [lale_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lms_adaptive_line_enhancer.sv -----
// LMS adaptive line enhancer, top level.
// Depends on lale_pkg, lale_in_if, lale_out_if and lale_cfg_if.
//
// One sample beat in gives one result beat out. Each sample is delayed by
// prediction_delay samples into a tap line; the block predicts the sample from
// the first tap_count taps with Q4.28 weights and then adapts those weights by
// 2*mu*error*tap. All arithmetic runs through one shared 32x16 signed
// multiplier, pipelined operand/product/accumulate, once per tap in the predict
// pass, once for mu*error and once per tap in the update pass. A result is
// made valid in the same cycle that samples.ready comes back, so a new sample
// is taken only after the previous result is formed; samples.ready is high only
// between items. A finished result waits in the output register while the
// next sample is taken; that next item then holds in its last state until
// the output register is free. A sample with last_sample set clears weights,
// tap line and delay line after its result is formed. Configuration writes
// are always ready and take effect at once, so issue them only between items.
`default_nettype none

module lms_adaptive_line_enhancer (
  input  logic      clk,
  input  logic      rst,
  lale_cfg_if.sink  cfg,
  lale_in_if.sink   samples,
  lale_out_if.source results
);
  import lale_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_PRED = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;
  localparam logic [2:0] S_KMUL = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_BITS-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > ACC_BITS'(S_MAX)) r = S_MAX;
    else if (v < ACC_BITS'(S_MIN)) r = S_MIN;
    else r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
    input logic signed [PROD_BITS:0] v);
    logic signed [WEIGHT_BITS-1:0] r;
    if (v > (PROD_BITS+1)'(W_MAX)) r = W_MAX;
    else if (v < (PROD_BITS+1)'(W_MIN)) r = W_MIN;
    else r = v[WEIGHT_BITS-1:0];
    return r;
  endfunction

  // Configuration registers
  logic [TAPCFG_BITS-1:0] tap_count;
  logic [MU_BITS-1:0]     step_size;
  logic [DLYCFG_BITS-1:0] prediction_delay;

  // Filter state
  logic signed [SAMPLE_BITS-1:0] delay_store  [MAX_DELAY];
  logic signed [SAMPLE_BITS-1:0] tap_line     [MAX_TAPS];
  logic signed [WEIGHT_BITS-1:0] weight_store [MAX_TAPS];

  // Sequencer and shared multiplier pipeline
  logic [2:0]                    state;
  logic [TAP_CW-1:0]             cnt;
  logic                          v1;
  logic                          v2;
  logic [TAP_IW-1:0]             idx1;
  logic [TAP_IW-1:0]             idx2;
  logic signed [OPA_BITS-1:0]    op_a;
  logic signed [SAMPLE_BITS-1:0] op_b;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [SAMPLE_BITS-1:0] d_r;
  logic                          last_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [SAMPLE_BITS-1:0] e_r;
  logic signed [OPA_BITS-1:0]    k_r;

  logic [TAP_CW-1:0]             n_taps;
  logic [DLY_CW-1:0]             n_dly;
  logic [DLY_CW-1:0]             dly_m1;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic                          accept;
  logic                          in_pass;
  logic [TAP_CW-1:0]             phase_n;
  logic                          issue;
  logic                          pass_done;
  logic                          out_free;
  logic [TAP_IW-1:0]             cidx;
  logic signed [OPA_BITS-1:0]    opa_next;
  logic signed [SAMPLE_BITS-1:0] opb_next;
  logic signed [ACC_BITS-1:0]    pred_sum;
  logic signed [ACC_BITS-1:0]    pred_sh;
  logic signed [PROD_BITS-1:0]   upd_sum;
  logic signed [PROD_BITS-1:0]   upd;
  logic signed [PROD_BITS:0]     w_sum;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count        <= TAP_COUNT_RST;
      step_size        <= STEP_SIZE_RST;
      prediction_delay <= PRED_DELAY_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TAP_COUNT:  tap_count        <= cfg.data[TAPCFG_BITS-1:0];
        CFG_STEP_SIZE:  step_size        <= cfg.data[MU_BITS-1:0];
        CFG_PRED_DELAY: prediction_delay <= cfg.data[DLYCFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tap_count == '0) n_taps = TAP_CW'(1);
    else if (tap_count > MAX_TAPS) n_taps = TAP_CW'(MAX_TAPS);
    else n_taps = TAP_CW'(tap_count);
    if (prediction_delay > MAX_DELAY) n_dly = DLY_CW'(MAX_DELAY);
    else n_dly = DLY_CW'(prediction_delay);
  end

  assign dly_m1 = n_dly - DLY_CW'(1);
  assign x_in   = (n_dly == '0) ? samples.sample_in : delay_store[dly_m1[DLY_IW-1:0]];

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;

  assign in_pass   = (state == S_MAC) || (state == S_KMUL) || (state == S_UPD);
  assign phase_n   = (state == S_KMUL) ? TAP_CW'(1) : n_taps;
  assign issue     = in_pass && (cnt < phase_n);
  assign pass_done = in_pass && !issue && !v1 && !v2;
  assign cidx      = cnt[TAP_IW-1:0];

  always_comb begin
    unique case (state)
      S_KMUL:  opa_next = $signed({{(OPA_BITS-MU_BITS){1'b0}}, step_size});
      S_UPD:   opa_next = k_r;
      default: opa_next = OPA_BITS'(weight_store[cidx]);
    endcase
    opb_next = (state == S_KMUL) ? e_r : tap_line[cidx];
  end

  // Round to nearest, ties up: add half an LSB, then arithmetic shift.
  assign pred_sum = acc + (ACC_BITS'(1) <<< (PRED_SHIFT - 1));
  assign pred_sh  = pred_sum >>> PRED_SHIFT;
  assign upd_sum  = prod + (PROD_BITS'(1) <<< (UPD_SHIFT - 1));
  assign upd      = upd_sum >>> UPD_SHIFT;
  assign w_sum    = (PROD_BITS+1)'(weight_store[idx2]) + (PROD_BITS+1)'(upd);

  // Operand and product stages; the accumulate stage is in the sequencer below
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
    idx1 <= cidx;
    idx2 <= idx1;
    if (issue) begin
      op_a <= opa_next;
      op_b <= opb_next;
    end
    if (v1) prod <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      results.valid  <= 1'b0;
      for (int i = 0; i < MAX_DELAY; i++) delay_store[i] <= '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        tap_line[i]     <= '0;
        weight_store[i] <= '0;
      end
    end else begin
      // S_DONE reloads the output register itself when it is free
      if (results.valid && results.ready && state != S_DONE) results.valid <= 1'b0;
      if (issue) cnt <= cnt + TAP_CW'(1);
      if (pass_done) cnt <= '0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            d_r    <= samples.sample_in;
            last_r <= samples.last_sample;
            acc    <= '0;
            for (int i = MAX_DELAY - 1; i > 0; i--) delay_store[i] <= delay_store[i-1];
            delay_store[0] <= samples.sample_in;
            for (int i = MAX_TAPS - 1; i > 0; i--) tap_line[i] <= tap_line[i-1];
            tap_line[0] <= x_in;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (v2) acc <= acc + ACC_BITS'(prod);
          if (pass_done) state <= S_PRED;
        end
        S_PRED: begin
          y_r   <= sat_sample(pred_sh);
          state <= S_ERR;
        end
        S_ERR: begin
          e_r   <= sat_sample(ACC_BITS'(d_r) - ACC_BITS'(y_r));
          state <= S_KMUL;
        end
        S_KMUL: begin
          // mu*e reused as operand A for every tap of the update pass
          if (v2) k_r <= prod[OPA_BITS-1:0];
          if (pass_done) state <= S_UPD;
        end
        S_UPD: begin
          if (v2) weight_store[idx2] <= sat_weight(w_sum);
          if (pass_done) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            results.valid      <= 1'b1;
            results.prediction <= y_r;
            results.pred_error <= e_r;
            if (last_r) begin
              for (int i = 0; i < MAX_DELAY; i++) delay_store[i] <= '0;
              for (int i = 0; i < MAX_TAPS; i++) begin
                tap_line[i]     <= '0;
                weight_store[i] <= '0;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !v1 && !v2 && cnt == '0)
    else $error("pipeline busy or counter set while idle");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MAC && cnt == '0 && !v1)
    else $error("accepted beat did not start a clean predict pass");

  a_prod_in_pass: assert property (@(posedge clk) disable iff (rst)
    v2 |-> in_pass)
    else $error("product landed outside an arithmetic pass");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free && last_r |=>
      weight_store[0] == '0 && tap_line[0] == '0 && delay_store[0] == '0)
    else $error("last sample did not clear filter state");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking bench for lms_adaptive_line_enhancer: directed table, then random phases.
// Needs lale_pkg, lale_in_if, lale_out_if, lale_cfg_if and the block from hdl/.
// Outputs are checked against an in-bench copy of the fixed-point LMS arithmetic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lale_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    int                       val;
    bit                       last;
    bit                       known;
    int                       pred;
    int                       err;
  } row_t;

  typedef struct {
    smp_t pred;
    smp_t err;
  } lms_out_t;

  typedef struct {
    bit   known;
    smp_t pred;
    smp_t err;
  } typed_out_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam longint S_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint S_MIN = -S_MAX - 1;
  localparam longint W_MAX = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
  localparam longint W_MIN = -W_MAX - 1;
  localparam int     HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;

  lale_in_if  samples();
  lale_out_if results();
  lale_cfg_if cfg();

  lms_adaptive_line_enhancer dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .results (results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Enhancer model state and arithmetic
  // ---------------------------------------------------------------------------
  smp_t                    hist_q [MAX_DELAY];  // past samples, newest first
  smp_t                    tapl_q [MAX_TAPS];   // filter inputs, newest first
  logic signed [WEIGHT_BITS-1:0] wt_q [MAX_TAPS];
  logic [TAPCFG_BITS-1:0]  m_taps;
  logic [MU_BITS-1:0]      m_mu;
  logic [DLYCFG_BITS-1:0]  m_dly;

  lms_out_t   lms_out_q[$];
  typed_out_t typed_q[$];

  int unsigned n_err, n_checked;
  bit          calm;

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // round to nearest, ties toward +inf
  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  task automatic clear_lms;
    int i;
    for (i = 0; i < MAX_DELAY; i++) hist_q[i] = '0;
    for (i = 0; i < MAX_TAPS; i++) begin
      tapl_q[i] = '0;
      wt_q[i]   = '0;
    end
  endtask

  task automatic enhance_step(input smp_t s, input logic last,
                              output smp_t y, output smp_t e);
    int     i, n_taps, dly;
    smp_t   x;
    longint acc, yv, ev, upd;
    n_taps = (m_taps == 0) ? 1 : ((m_taps > MAX_TAPS) ? MAX_TAPS : int'(m_taps));
    dly    = (m_dly > MAX_DELAY) ? MAX_DELAY : int'(m_dly);
    x      = (dly == 0) ? s : hist_q[dly-1];
    for (i = MAX_DELAY - 1; i > 0; i--) hist_q[i] = hist_q[i-1];
    hist_q[0] = s;
    for (i = MAX_TAPS - 1; i > 0; i--) tapl_q[i] = tapl_q[i-1];
    tapl_q[0] = x;
    acc = 0;
    for (i = 0; i < n_taps; i++) acc += longint'(wt_q[i]) * longint'(tapl_q[i]);
    yv = sat(round_sh(acc, PRED_SHIFT), S_MIN, S_MAX);
    ev = sat(longint'(s) - yv, S_MIN, S_MAX);
    for (i = 0; i < n_taps; i++) begin
      upd = round_sh(longint'(m_mu) * ev * longint'(tapl_q[i]), UPD_SHIFT);
      wt_q[i] = WEIGHT_BITS'(sat(longint'(wt_q[i]) + upd, W_MIN, W_MAX));
    end
    y = smp_t'(yv);
    e = smp_t'(ev);
    if (last) clear_lms();
  endtask

  task automatic report_miss(input string msg);
    n_err++;
    if (n_err <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // Checks output beats, tracks register writes, predicts each accepted sample.
  always @(posedge clk) begin : track_lms
    lms_out_t   want;
    typed_out_t mark;
    smp_t       y, e;
    if (rst) begin
      m_taps = TAP_COUNT_RST;
      m_mu   = STEP_SIZE_RST;
      m_dly  = PRED_DELAY_RST;
      clear_lms();
      lms_out_q.delete();
    end else begin
      if (results.valid && results.ready) begin
        n_checked++;
        if (lms_out_q.size() == 0) begin
          report_miss($sformatf("result beat with none pending: pred=%0d err=%0d",
                                results.prediction, results.pred_error));
        end else begin
          want = lms_out_q.pop_front();
          if (results.prediction !== want.pred)
            report_miss($sformatf("prediction exp=%0d got=%0d", want.pred,
                                  results.prediction));
          if (results.pred_error !== want.err)
            report_miss($sformatf("pred_error exp=%0d got=%0d", want.err,
                                  results.pred_error));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TAP_COUNT:  m_taps = cfg.data[TAPCFG_BITS-1:0];
          CFG_STEP_SIZE:  m_mu   = cfg.data[MU_BITS-1:0];
          CFG_PRED_DELAY: m_dly  = cfg.data[DLYCFG_BITS-1:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        enhance_step(samples.sample_in, samples.last_sample, y, e);
        mark = typed_q.pop_front();
        if (mark.known) lms_out_q.push_back('{mark.pred, mark.err});
        else            lms_out_q.push_back('{y, e});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random ready, with two long hold-offs to back the block up
  // ---------------------------------------------------------------------------
  int unsigned hold_left, run_left, seen_smp;

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      hold_left = 0;
      run_left  = 0;
      seen_smp  = 0;
    end else begin
      if (samples.valid && samples.ready) begin
        seen_smp++;
        if (seen_smp == 150 || seen_smp == 450) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        results.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        results.ready <= 1'b1;
      end else if (run_left != 0) begin
        run_left--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            results.ready <= 1'b1;
            run_left = $urandom_range(0, 20);
          end
          9: begin
            results.ready <= 1'b0;
            run_left = $urandom_range(20, 80);
          end
          default: begin
            results.ready <= 1'b0;
            run_left = $urandom_range(0, 3);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_sample(input int val, input bit last, input bit known,
                             input int pred, input int err);
    int unsigned gap, r;
    typed_q.push_back('{known, smp_t'(pred), smp_t'(err)});
    samples.valid       <= 1'b1;
    samples.sample_in   <= smp_t'(val);
    samples.last_sample <= last;
    do @(posedge clk); while (!samples.ready);
    r = $urandom_range(0, 99);
    if (calm || r < 60) gap = 0;
    else if (r < 92)    gap = $urandom_range(1, 3);
    else                gap = $urandom_range(10, 50);
    if (gap != 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // every result back, then wait on so the block is between items
  task automatic wait_idle;
    samples.valid <= 1'b0;
    do @(posedge clk); while (lms_out_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic row_t smp_row(int val, bit last, bit known, int pred, int err);
    return '{ROW_SMP, CFG_TAP_COUNT, val, last, known, pred, err};
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_BITS-1:0] idx, int val);
    return '{ROW_CFG, idx, val, 1'b0, 1'b0, 0, 0};
  endfunction

  row_t                     dir_tbl[$];
  int unsigned              n_dir, n_rand, n_phases, burst, mode, period, k;
  int                       v, pat[16];
  bit                       prev_smp, last;
  logic [CFG_DATA_BITS-1:0] wd;

  initial begin
    rst                 = 1'b1;
    calm                = 1'b0;
    samples.valid       = 1'b0;
    samples.sample_in   = '0;
    samples.last_sample = 1'b0;
    results.ready       = 1'b0;
    cfg.valid           = 1'b0;
    cfg.index           = CFG_TAP_COUNT;
    cfg.data            = '0;

    // Reset settings, fresh state: weights zero, so the first items predict 0.
    dir_tbl.push_back(smp_row( 32767, 0, 1, 0,  32767));
    dir_tbl.push_back(smp_row(-32768, 0, 1, 0, -32768));
    dir_tbl.push_back(smp_row(     1, 0, 1, 0,      1));
    dir_tbl.push_back(smp_row(    -1, 0, 1, 0,     -1));
    dir_tbl.push_back(smp_row(     0, 0, 1, 0,      0));
    dir_tbl.push_back(smp_row( 12345, 0, 1, 0,  12345));
    dir_tbl.push_back(smp_row( 32767, 0, 0, 0, 0));
    dir_tbl.push_back(smp_row( 32767, 0, 0, 0, 0));
    dir_tbl.push_back(smp_row(-32768, 0, 0, 0, 0));
    dir_tbl.push_back(smp_row( 20000, 0, 0, 0, 0));
    dir_tbl.push_back(smp_row(-20000, 1, 0, 0, 0));
    dir_tbl.push_back(smp_row(  5000, 1, 1, 0,   5000));  // state was cleared
    // tap count 0 acts as 1, full step, zero delay; upper data bits are dropped
    dir_tbl.push_back(reg_row(CFG_TAP_COUNT,  16'hFFC0));
    dir_tbl.push_back(reg_row(CFG_STEP_SIZE,  16'hFFFF));
    dir_tbl.push_back(reg_row(CFG_PRED_DELAY, 16'hFFE0));
    dir_tbl.push_back(smp_row( 32767, 0, 1, 0,  32767));
    dir_tbl.push_back(smp_row( 32767, 0, 0, 0, 0));
    dir_tbl.push_back(smp_row(-32768, 0, 0, 0, 0));
    dir_tbl.push_back(smp_row(-32768, 0, 0, 0, 0));
    dir_tbl.push_back(smp_row( 16384, 1, 0, 0, 0));
    // oversized tap count and delay saturate; zero step keeps weights at zero
    dir_tbl.push_back(reg_row(CFG_TAP_COUNT,  16'h003F));
    dir_tbl.push_back(reg_row(CFG_PRED_DELAY, 16'h001F));
    dir_tbl.push_back(reg_row(CFG_STEP_SIZE,  16'h0000));
    dir_tbl.push_back(reg_row(CFG_UNUSED,     16'hFFFF));
    dir_tbl.push_back(smp_row(   100, 0, 1, 0,    100));
    dir_tbl.push_back(smp_row(-32768, 0, 1, 0, -32768));
    dir_tbl.push_back(smp_row( 32767, 1, 1, 0,  32767));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    prev_smp = 1'b0;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        if (prev_smp) wait_idle();
        prev_smp = 1'b0;
        reg_write(dir_tbl[i].idx, CFG_DATA_BITS'(dir_tbl[i].val));
      end else begin
        send_sample(dir_tbl[i].val, dir_tbl[i].last, dir_tbl[i].known,
                    dir_tbl[i].pred, dir_tbl[i].err);
        prev_smp = 1'b1;
        n_dir++;
      end
    end

    while (n_rand < 600) begin
      wait_idle();
      calm = 1'b0;
      wd = CFG_DATA_BITS'($urandom);
      case ($urandom_range(0, 8))
        0: wd[5:0] = 6'd0;
        1: wd[5:0] = 6'd1;
        2: wd[5:0] = 6'd2;
        3: wd[5:0] = 6'd31;
        4: wd[5:0] = 6'd32;
        5: wd[5:0] = 6'd33;
        6: wd[5:0] = 6'd63;
        default: ;
      endcase
      reg_write(CFG_TAP_COUNT, wd);
      case ($urandom_range(0, 6))
        0: wd = 16'd0;
        1: wd = 16'd1;
        2: wd = STEP_SIZE_RST;
        3: wd = 16'hFFFF;
        4: wd = 16'd1 << $urandom_range(0, 15);
        default: wd = CFG_DATA_BITS'($urandom);
      endcase
      reg_write(CFG_STEP_SIZE, wd);
      wd = CFG_DATA_BITS'($urandom);
      case ($urandom_range(0, 7))
        0: wd[4:0] = 5'd0;
        1: wd[4:0] = 5'd1;
        2: wd[4:0] = 5'd15;
        3: wd[4:0] = 5'd16;
        4: wd[4:0] = 5'd17;
        5: wd[4:0] = 5'd31;
        default: ;
      endcase
      reg_write(CFG_PRED_DELAY, wd);
      if ($urandom_range(0, 5) == 0) reg_write(CFG_UNUSED, 16'($urandom));

      calm   = ($urandom_range(0, 4) == 0);
      burst  = $urandom_range(8, 48);
      mode   = $urandom_range(0, 3);
      period = $urandom_range(2, 9);
      v      = $urandom_range(256, 32767);  // tone amplitude
      for (k = 0; k < period; k++) pat[k] = $urandom_range(0, 2 * v) - v;
      for (k = 0; k < burst; k++) begin
        case (mode)
          0: v = int'(smp_t'($urandom));
          1: case ($urandom_range(0, 4))
               0: v = 32767;
               1: v = -32768;
               2: v = 0;
               3: v = -1;
               default: v = 1;
             endcase
          2: begin
            // periodic tone plus a little noise: the weights get to converge
            v = pat[k % period] + $urandom_range(0, 63) - 32;
            if (v > 32767)  v = 32767;
            if (v < -32768) v = -32768;
          end
          default: v = $urandom_range(0, 511) - 256;
        endcase
        last = (k == burst - 1) ? ($urandom_range(0, 1) == 1)
                                : ($urandom_range(0, 49) == 0);
        send_sample(v, last, 1'b0, 0, 0);
        n_rand++;
      end
      n_phases++;
    end

    wait_idle();
    calm = 1'b0;
    repeat (100) @(posedge clk);
    n_err += lms_out_q.size();

    $display("Covered %0d directed and %0d random samples over %0d random register phases",
             n_dir, n_rand, n_phases);
    $display("Checked %0d result beats, %0d failures", n_checked, n_err);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d results still pending", lms_out_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
